// ----- sv/ptw_pkg.sv -----
// Shared constants and types for the page table walker.
// Used by ptw_ctrl, ptw_dp and the page_table_walk_and_map top level.
package ptw_pkg;

  localparam int TABLE_PAGES = 64;
  localparam int IDX_W       = 9;
  localparam int OFS_W       = 12;
  localparam int SLOT_W      = $clog2(TABLE_PAGES);
  localparam int NT_W        = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W      = SLOT_W + IDX_W;
  localparam int DEPTH       = TABLE_PAGES * (1 << IDX_W);
  localparam int VA_W        = 48;
  localparam int PA_W        = 52;
  localparam int FLG_W       = 12;
  localparam int ENT_W       = 64;
  localparam int EPG_W       = ENT_W - OFS_W;
  localparam int PG_W        = PA_W - OFS_W + 1;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 56;
  localparam int CFG_DATA_W  = 56;

  localparam logic [OFS_W-1:0]  LINK_FLAGS    = 12'h007;
  localparam logic [PG_W-1:0]   BASE_PAGE_RST = 41'h100;
  localparam logic [NT_W-1:0]   NEXT_TAB_RST  = NT_W'(1);
  localparam logic [1:0]        LVL_LEAF      = 2'd3;
  localparam logic [1:0]        LVL_LAST_DIR  = 2'd2;
  localparam logic              CMD_MAP       = 1'b1;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_MISS,
    RES_XLATE,
    RES_OOT,
    RES_MAPPED
  } res_kind_t;

  typedef struct packed {
    logic      clr;
    logic      load;
    logic      rd;
    logic      adv;
    logic      wr_link;
    logic      wr_leaf;
    logic      emit;
    res_kind_t res;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_map;
    logic hit;
    logic leaf_present;
    logic no_room;
    logic lvl2;
    logic lvl3;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- sv/ptw_ctrl.sv -----
// Controller state machine of the page table walker.
// Depends on ptw_pkg; drives commands into ptw_dp and reads its status.
module ptw_ctrl import ptw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_WLINK,
    S_WLEAF,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res   = RES_NONE;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.lvl3) begin
          cmd.res   = sts.leaf_present ? RES_XLATE : RES_MISS;
          state_nxt = S_RESP;
        end else if (sts.hit) begin
          cmd.adv   = 1'b1;
          state_nxt = (sts.is_map && sts.lvl2) ? S_WLEAF : S_RD;
        end else if (!sts.is_map) begin
          cmd.res   = RES_MISS;
          state_nxt = S_RESP;
        end else if (sts.no_room) begin
          cmd.res   = RES_OOT;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_WLINK;
        end
      end
      S_WLINK: begin
        cmd.wr_link = 1'b1;
        if (sts.lvl2) begin
          state_nxt = S_WLEAF;
        end
      end
      S_WLEAF: begin
        cmd.wr_leaf = 1'b1;
        cmd.res     = RES_MAPPED;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/ptw_dp.sv -----
// Datapath of the page table walker: table store, walk registers,
// pool base register and result register. Depends on ptw_pkg.
module ptw_dp import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic                  in_cmd,
  input  logic [VA_W-1:0]       in_virt,
  input  logic [PA_W-1:0]       in_phys,
  input  logic [FLG_W-1:0]      in_flags,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PA_W-1:0]       cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PA_W-1:0]       out_phys,
  output logic                  out_found,
  output logic                  out_oot
);

  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              cmd_r;
  logic [VA_W-1:0]   virt_r;
  logic [PA_W-1:0]   phys_r;
  logic [FLG_W-1:0]  flags_r;
  logic [1:0]        lvl_r;
  logic [SLOT_W-1:0] slot_r;
  logic [NT_W-1:0]   next_tab_r;
  logic [PG_W-1:0]   base_page_r;
  logic [PA_W-1:0]   res_phys_r;
  logic              res_found_r;
  logic              res_oot_r;
  logic              out_valid_r;
  logic [PA_W-1:0]   out_phys_r;
  logic              out_found_r;
  logic              out_oot_r;

  logic [IDX_W-1:0]  idx_sel;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;
  logic              we;
  logic [EPG_W-1:0]  epage;
  logic [EPG_W-1:0]  base_ext;
  logic [EPG_W-1:0]  diff;
  logic              hit;
  logic [PG_W:0]     link_page;
  logic [NT_W:0]     need_sum;
  logic [PG_W-1:0]   cfg_page;

  always_comb begin
    case (lvl_r)
      2'd0:    idx_sel = virt_r[47:39];
      2'd1:    idx_sel = virt_r[38:30];
      2'd2:    idx_sel = virt_r[29:21];
      default: idx_sel = virt_r[20:12];
    endcase
  end

  assign walk_addr = {slot_r, idx_sel};
  assign epage     = rdata_r[ENT_W-1:OFS_W];
  assign base_ext  = {{(EPG_W-PG_W){1'b0}}, base_page_r};
  assign diff      = epage - base_ext;
  assign hit       = rdata_r[0] && (epage >= base_ext) &&
                     (diff < {{(EPG_W-NT_W){1'b0}}, next_tab_r});
  assign link_page = {1'b0, base_page_r} + {{(PG_W+1-NT_W){1'b0}}, next_tab_r};
  assign need_sum  = {1'b0, next_tab_r} + {{(NT_W-1){1'b0}}, LVL_LEAF - lvl_r};
  assign cfg_page  = {1'b0, cfg_data[PA_W-1:OFS_W]} + PG_W'(|cfg_data[OFS_W-1:0]);

  always_comb begin
    we    = 1'b0;
    waddr = walk_addr;
    wdata = '0;
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_addr_r;
    end else if (cmd.wr_link) begin
      we    = 1'b1;
      wdata = {{(ENT_W-OFS_W-PG_W-1){1'b0}}, link_page, LINK_FLAGS};
    end else if (cmd.wr_leaf) begin
      we    = 1'b1;
      wdata = {{(ENT_W-PA_W){1'b0}}, phys_r} | {{(ENT_W-FLG_W){1'b0}}, flags_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      lvl_r       <= '0;
      slot_r      <= '0;
      next_tab_r  <= NEXT_TAB_RST;
      base_page_r <= BASE_PAGE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cfg_valid) begin
        base_page_r <= cfg_page;
      end
      if (cmd.load) begin
        lvl_r  <= '0;
        slot_r <= '0;
      end else if (cmd.adv) begin
        lvl_r  <= lvl_r + 2'd1;
        slot_r <= diff[SLOT_W-1:0];
      end else if (cmd.wr_link) begin
        lvl_r      <= lvl_r + 2'd1;
        slot_r     <= next_tab_r[SLOT_W-1:0];
        next_tab_r <= next_tab_r + NT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      virt_r  <= in_virt;
      phys_r  <= in_phys;
      flags_r <= in_flags;
    end
    case (cmd.res)
      RES_MISS: begin
        res_phys_r  <= '0;
        res_found_r <= 1'b0;
        res_oot_r   <= 1'b0;
      end
      RES_XLATE: begin
        res_phys_r  <= {rdata_r[PA_W-1:OFS_W], virt_r[OFS_W-1:0]};
        res_found_r <= 1'b1;
        res_oot_r   <= 1'b0;
      end
      RES_OOT: begin
        res_phys_r  <= '0;
        res_found_r <= 1'b0;
        res_oot_r   <= 1'b1;
      end
      RES_MAPPED: begin
        res_phys_r  <= '0;
        res_found_r <= 1'b1;
        res_oot_r   <= 1'b0;
      end
      default: begin
      end
    endcase
    if (cmd.emit) begin
      out_phys_r  <= res_phys_r;
      out_found_r <= res_found_r;
      out_oot_r   <= res_oot_r;
    end
  end

  assign sts.clr_done     = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign sts.is_map       = (cmd_r == CMD_MAP);
  assign sts.hit          = hit;
  assign sts.leaf_present = rdata_r[0];
  assign sts.no_room      = (need_sum > (NT_W+1)'(TABLE_PAGES));
  assign sts.lvl2         = (lvl_r == LVL_LAST_DIR);
  assign sts.lvl3         = (lvl_r == LVL_LEAF);
  assign sts.out_free     = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_phys  = out_phys_r;
  assign out_found = out_found_r;
  assign out_oot   = out_oot_r;

endmodule

// ----- sv/page_table_walk_and_map.sv -----
// After reset the block clears all 32768 entries of its table store, one
// entry per cycle, and accepts no item until that is done; configuration
// writes are taken at any time. Each table level takes a read state and a
// check state through the single-port table memory with its registered read.
// A completed map writes up to four table entries: up to three links and the
// leaf. One result is held in an output register, so the next item is
// accepted while a finished result waits to be taken.
// Depends on ptw_pkg, ptw_ctrl and ptw_dp.
module page_table_walk_and_map import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [47:0] virt_addr, [99:48] phys_addr_in, [111:100] page_flags.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] cmd.
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [51:0] phys_addr, upper bits zero.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] found, [1] out_of_tables.
  output logic [1:0]            out_tuser,
  input  logic                  cfg_tvalid,
  output logic                  cfg_tready,
  // [51:0] pool_base, upper bits ignored.
  input  logic [CFG_DATA_W-1:0] cfg_tdata
);

  ctl_cmd_t        cmd;
  dp_sts_t         sts;
  logic [PA_W-1:0] out_phys;
  logic            out_found;
  logic            out_oot;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_cmd    (in_tuser),
    .in_virt   (in_tdata[VA_W-1:0]),
    .in_phys   (in_tdata[VA_W+PA_W-1:VA_W]),
    .in_flags  (in_tdata[VA_W+PA_W+FLG_W-1:VA_W+PA_W]),
    .cfg_valid (cfg_tvalid),
    .cfg_ready (cfg_tready),
    .cfg_data  (cfg_tdata[PA_W-1:0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_phys  (out_phys),
    .out_found (out_found),
    .out_oot   (out_oot)
  );

  assign out_tdata = {{(OUT_DATA_W-PA_W){1'b0}}, out_phys};
  assign out_tuser = {out_oot, out_found};

endmodule

// ----- test/page_table_walk_and_map_checker.sv -----
`timescale 1ns / 100ps
// Checker for the page table walker: watches the item, result and pool_base channels,
// keeps its own copy of the table pool and compares every result with its prediction.
// Depends on ptw_pkg for widths and codes.
module page_table_walk_and_map_checker import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  cfg_tvalid,
  input  logic                  cfg_tready,
  input  logic [CFG_DATA_W-1:0] cfg_tdata,
  output int                    pending,
  output int                    errors,
  output int                    n_hits,
  output int                    n_mapped,
  output int                    n_full
);

  localparam int          ENTRIES       = 1 << IDX_W;
  localparam logic [51:0] POOL_BASE_RST = 52'h10_0000;

  typedef struct packed {
    logic [PA_W-1:0] phys;
    logic            found;
    logic            full;
  } walk_result_t;

  logic [ENT_W-1:0] tables [DEPTH];
  int               next_free;
  logic [PA_W-1:0]  pool_base;
  walk_result_t     awaited_walks [$];

  initial begin
    errors   = 0;
    n_hits   = 0;
    n_mapped = 0;
    n_full   = 0;
    pending  = 0;
  end

  function automatic logic [ENT_W-1:0] pool_origin();
    return ({{(ENT_W-PA_W){1'b0}}, pool_base} + 64'hFFF) & ~64'hFFF;
  endfunction

  // Slot that a directory entry points to, or -1 when it is absent or outside the pool.
  function automatic int link_slot(input logic [ENT_W-1:0] entry);
    logic [ENT_W-1:0] addr;
    logic [ENT_W-1:0] org;
    logic [ENT_W-1:0] slot;
    if (!entry[0]) return -1;
    addr = {entry[ENT_W-1:OFS_W], {OFS_W{1'b0}}};
    org  = pool_origin();
    if (addr < org) return -1;
    slot = (addr - org) >> OFS_W;
    if (slot >= 64'(next_free) || slot >= 64'(TABLE_PAGES)) return -1;
    return int'(slot);
  endfunction

  task automatic walk_tables(input logic cmd, input logic [VA_W-1:0] va,
                             input logic [PA_W-1:0] pa, input logic [FLG_W-1:0] flg,
                             output walk_result_t res);
    logic [IDX_W-1:0] idx [4];
    logic [ENT_W-1:0] leaf;
    int               slot;
    int               nx;
    int               lvl;
    int               needed;
    int               fresh;
    bit               miss;
    idx[0] = va[47:39];
    idx[1] = va[38:30];
    idx[2] = va[29:21];
    idx[3] = va[20:12];
    res    = '0;
    slot   = 0;
    needed = 0;
    miss   = 1'b0;
    for (lvl = 0; lvl < 3 && !miss; lvl++) begin
      nx = link_slot(tables[slot * ENTRIES + int'(idx[lvl])]);
      if (nx < 0) begin
        miss   = 1'b1;
        needed = 3 - lvl;
      end else begin
        slot = nx;
      end
    end
    if (cmd != CMD_MAP) begin
      leaf = tables[slot * ENTRIES + int'(idx[3])];
      if (!miss && leaf[0]) begin
        res.phys  = {leaf[PA_W-1:OFS_W], va[OFS_W-1:0]};
        res.found = 1'b1;
        n_hits++;
      end
    end else if (next_free + needed > TABLE_PAGES) begin
      res.full = 1'b1;
      n_full++;
    end else begin
      slot = 0;
      for (lvl = 0; lvl < 3; lvl++) begin
        nx = link_slot(tables[slot * ENTRIES + int'(idx[lvl])]);
        if (nx < 0) begin
          fresh = next_free;
          next_free++;
          for (int e = 0; e < ENTRIES; e++) tables[fresh * ENTRIES + e] = '0;
          tables[slot * ENTRIES + int'(idx[lvl])] =
            (pool_origin() + 64'(fresh) * 64'h1000) | {52'd0, LINK_FLAGS};
          slot = fresh;
        end else begin
          slot = nx;
        end
      end
      tables[slot * ENTRIES + int'(idx[3])] = {12'd0, pa} | {52'd0, flg};
      res.found = 1'b1;
      n_mapped++;
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : track
    walk_result_t want;
    walk_result_t fresh_res;
    if (!rst_n) begin
      foreach (tables[i]) tables[i] = '0;
      next_free = 1;
      pool_base = POOL_BASE_RST;
      awaited_walks.delete();
    end else begin
      if (cfg_tvalid && cfg_tready) pool_base = cfg_tdata[PA_W-1:0];
      if (out_tvalid && out_tready) begin
        if (awaited_walks.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual data 0x%0h user 0x%0h",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = awaited_walks.pop_front();
          compare_field("phys_addr", 64'(want.phys), 64'(out_tdata));
          compare_field("found", 64'(want.found), 64'(out_tuser[0]));
          compare_field("out_of_tables", 64'(want.full), 64'(out_tuser[1]));
        end
      end
      if (in_tvalid && in_tready) begin
        walk_tables(in_tuser, in_tdata[VA_W-1:0], in_tdata[VA_W+PA_W-1:VA_W],
                    in_tdata[IN_DATA_W-1:VA_W+PA_W], fresh_res);
        awaited_walks.push_back(fresh_res);
      end
    end
    pending <= awaited_walks.size();
  end

endmodule

// ----- test/page_table_walk_and_map_tb.sv -----
`timescale 1ns / 100ps
// Top of the page table walker testbench: clock, reset, item and pool_base stimulus,
// random stalls on both sides, watchdog and verdict. Depends on ptw_pkg, the block
// page_table_walk_and_map and page_table_walk_and_map_checker.
module page_table_walk_and_map_tb import ptw_pkg::*;;

  localparam logic CMD_XLATE  = 1'b0;
  localparam int   IDLE_LIMIT = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_tvalid;
  logic                  cfg_tready;
  logic [CFG_DATA_W-1:0] cfg_tdata;

  int pending;
  int errors;
  int n_hits;
  int n_mapped;
  int n_full;
  int items_sent = 0;
  int idle_cycles = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit hold_done = 1'b0;

  logic [IDX_W-1:0] hot_l4 [4];
  logic [IDX_W-1:0] hot_l3 [3];
  logic [IDX_W-1:0] hot_l2 [3];

  page_table_walk_and_map i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  page_table_walk_and_map_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .pending    (pending),
    .errors     (errors),
    .n_hits     (n_hits),
    .n_mapped   (n_mapped),
    .n_full     (n_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic cmd, input logic [VA_W-1:0] va,
                           input logic [PA_W-1:0] pa, input logic [FLG_W-1:0] flg);
    if (!in_calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {flg, pa, va};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
  endtask

  task automatic write_pool_base(input logic [CFG_DATA_W-1:0] value);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Most addresses fall on a few hot paths so that maps and translates meet;
  // the rest are fully random.
  task automatic run_random(input int unsigned count);
    logic [VA_W-1:0]  va;
    logic [PA_W-1:0]  pa;
    logic [FLG_W-1:0] flg;
    logic [IDX_W-1:0] leaf_idx;
    logic             cmd;
    int unsigned      roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        va = 48'({$urandom, $urandom});
      end else begin
        leaf_idx = ($urandom_range(0, 7) < 6) ? 9'($urandom_range(0, 3)) : 9'($urandom);
        va = {hot_l4[$urandom_range(0, 3)], hot_l3[$urandom_range(0, 2)],
              hot_l2[$urandom_range(0, 2)], leaf_idx, 12'($urandom)};
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) pa = '0;
      else if (roll == 1) pa = '1;
      else pa = 52'({$urandom, $urandom});
      flg    = 12'($urandom);
      flg[0] = ($urandom_range(0, 9) != 0);
      cmd    = ($urandom_range(0, 99) < 45) ? CMD_MAP : CMD_XLATE;
      send_item(cmd, va, pa, flg);
    end
  endtask

  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= 60) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (!out_calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_tvalid && cfg_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_XLATE;
    cfg_tvalid <= 1'b0;
    cfg_tdata  <= '0;
    hot_l4 = '{9'd0, 9'd511, 9'($urandom), 9'($urandom)};
    hot_l3 = '{9'd0, 9'd511, 9'($urandom)};
    hot_l2 = '{9'd0, 9'd511, 9'($urandom)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_pool_base('0);
    send_item(CMD_XLATE, 48'h0000_0000_0000, '0, '0);
    send_item(CMD_XLATE, 48'hFFFF_FFFF_FFFF, '1, '1);
    send_item(CMD_MAP,   48'h0000_0000_0000, '0, '0);
    send_item(CMD_XLATE, 48'h0000_0000_0000, '0, '0);
    send_item(CMD_MAP,   48'h0000_0000_0000, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
    send_item(CMD_XLATE, 48'h0000_0000_0FFF, '0, '0);
    send_item(CMD_MAP,   48'hFFFF_FFFF_FFFF, 52'h8_0000_0000_0000, 12'h001);
    send_item(CMD_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
    send_item(CMD_MAP,   48'h0000_0000_1000, 52'h1_2345_6789_A000, 12'h003);
    send_item(CMD_XLATE, 48'h0000_0000_1ABC, '0, '0);
    send_item(CMD_MAP,   48'h0000_0000_2000, 52'h0_0000_0000_0FFF, 12'h000);
    send_item(CMD_XLATE, 48'h0000_0000_2555, '0, '0);
    send_item(CMD_XLATE, 48'h0000_4000_0000, '0, '0);
    send_item(CMD_XLATE, 48'h0000_0020_0000, '0, '0);
    send_item(CMD_MAP,   48'h0000_0000_0000, 52'hA_5A5A_5A5A_5000, 12'h800);
    send_item(CMD_XLATE, 48'h0000_0000_0123, '0, '0);
    run_random(170);
    drain();

    write_pool_base(56'h00_0000_0000_0001);
    run_random(170);
    drain();

    write_pool_base('1);
    run_random(170);
    drain();

    write_pool_base('0);
    run_random(170);
    drain();

    $display("Ran %0d items over four pool_base settings (zero, unaligned, all ones, zero).",
             items_sent);
    $display("Translate hits: %0d, maps completed: %0d, maps refused for lack of tables: %0d.",
             n_hits, n_mapped, n_full);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ptw_pkg.sv
sv/ptw_ctrl.sv
sv/ptw_dp.sv
sv/page_table_walk_and_map.sv
test/page_table_walk_and_map_checker.sv
test/page_table_walk_and_map_tb.sv
